// ===== rtl/mblp_pkg.sv =====
package mblp_pkg;

    // Button classes as kept per button and reported on the query field.
    typedef enum logic [2:0] {
        CLS_REST       = 3'd0,
        CLS_PRESSED    = 3'd1,
        CLS_STILL      = 3'd2,
        CLS_LONG       = 3'd3,
        CLS_STILL_LONG = 3'd4,
        CLS_RELEASED   = 3'd5
    } t_class;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_HOLD
    } t_state;

    // Register word index on the configuration port (byte address / 4).
    localparam logic REG_LONG_PRESS = 1'b0;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam logic [31:0] LONG_PRESS_RESET = 32'd1000;

    localparam int unsigned MASK_W  = 16;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned QUERY_W = 4;

    typedef struct packed {
        logic load;     // capture a new scan word and restart the sweep
        logic step;     // process the button at the head of the ring
        logic publish;  // copy the sweep result into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic last;     // the head of the ring is the highest button
    } t_dp_status;

endpackage

// ===== rtl/mblp_ctrl.sv =====
module mblp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    input  mblp_pkg::t_dp_status i_status,
    output mblp_pkg::t_dp_cmd    o_cmd
);
    import mblp_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_status.last) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    o_cmd.publish = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/mblp_datapath.sv =====
module mblp_datapath #(
    parameter int unsigned BUTTONS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mblp_pkg::t_dp_cmd                 i_cmd,
    output mblp_pkg::t_dp_status              o_status,
    input  logic [31:0]                       i_long_press_ms,
    input  logic [mblp_pkg::MASK_W-1:0]       i_pressed_mask,
    input  logic [mblp_pkg::TIME_W-1:0]       i_now_ms,
    input  logic [mblp_pkg::QUERY_W-1:0]      i_query_button,
    output logic                              o_any_active,
    output logic [3:0]                        o_first_button,
    output logic [2:0]                        o_query_state
);
    import mblp_pkg::*;

    localparam int unsigned IDX_W = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
    localparam int unsigned CMP_W = 8;

    // Class and press time rotate through a ring: the head is the button
    // being processed and its new value enters at the tail, so after a full
    // sweep every button is back in place.
    t_class             r_cls  [BUTTONS];
    logic [TIME_W-1:0]  r_time [BUTTONS];

    logic [MASK_W-1:0]  r_mask;
    logic [TIME_W-1:0]  r_now;
    logic [QUERY_W-1:0] r_query;
    logic [IDX_W-1:0]   r_cnt;
    logic               r_found;
    logic [3:0]         r_first;
    logic [2:0]         r_qstate;
    logic               r_any_out;
    logic [3:0]         r_first_out;
    logic [2:0]         r_qstate_out;

    t_class             head_cls;
    logic [TIME_W-1:0]  head_time;
    logic [TIME_W-1:0]  held;
    logic               down;
    t_class             new_cls;
    logic [TIME_W-1:0]  new_time;

    assign head_cls  = r_cls[0];
    assign head_time = r_time[0];
    assign down      = r_mask[0];
    assign held      = r_now - head_time;

    always_comb begin
        new_cls  = head_cls;
        new_time = head_time;
        if (down) begin
            case (head_cls)
                CLS_PRESSED: new_cls = CLS_STILL;
                CLS_STILL: begin
                    if (held > i_long_press_ms) begin
                        new_cls = CLS_LONG;
                    end
                end
                CLS_LONG, CLS_STILL_LONG: new_cls = CLS_STILL_LONG;
                default: begin
                    new_cls  = CLS_PRESSED;
                    new_time = r_now;
                end
            endcase
        end else begin
            case (head_cls)
                CLS_PRESSED, CLS_STILL, CLS_LONG, CLS_STILL_LONG: begin
                    new_cls = CLS_RELEASED;
                end
                default: begin
                    new_cls  = CLS_REST;
                    new_time = '0;
                end
            endcase
        end
    end

    assign o_status.last = (r_cnt == IDX_W'(BUTTONS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BUTTONS; i++) begin
                r_cls[i] <= CLS_REST;
            end
        end else if (i_cmd.step) begin
            for (int i = 0; i < BUTTONS - 1; i++) begin
                r_cls[i] <= r_cls[i + 1];
            end
            r_cls[BUTTONS - 1] <= new_cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            for (int i = 0; i < BUTTONS - 1; i++) begin
                r_time[i] <= r_time[i + 1];
            end
            r_time[BUTTONS - 1] <= new_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mask   <= i_pressed_mask;
            r_now    <= i_now_ms;
            r_query  <= i_query_button;
            r_cnt    <= '0;
            r_found  <= 1'b0;
            r_first  <= '0;
            r_qstate <= CLS_REST;
        end else if (i_cmd.step) begin
            // Buttons beyond the mask width shift in as released.
            r_mask <= r_mask >> 1;
            r_cnt  <= r_cnt + 1'b1;
            if (!r_found && new_cls != CLS_REST) begin
                r_found <= 1'b1;
                r_first <= 4'(r_cnt);
            end
            if (CMP_W'(r_cnt) == CMP_W'(r_query)) begin
                r_qstate <= new_cls;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_any_out    <= r_found;
            r_first_out  <= r_first;
            r_qstate_out <= r_qstate;
        end
    end

    assign o_any_active   = r_any_out;
    assign o_first_button = r_first_out;
    assign o_query_state  = r_qstate_out;

endmodule

// ===== rtl/multi_button_long_press_tracker.sv =====
// Long-press tracker for a bank of push buttons.
// The input channel (i_in_valid / o_in_stall) carries one scan word: the
// pressed-bit mask, the current millisecond time and a query button. The
// output channel (o_out_valid / i_out_stall) returns one word per scan: whether
// any button is away from rest, the lowest such button, and the class of the
// queried button after this scan's update.
// The datapath visits one button per cycle through a rotating ring of class
// and press-time registers. An accepted word is swept over every button,
// then the result is published from the hold state; the input stays stalled
// until the block is back in idle, so a new word is taken only after that.
// The output register holds the last result while the next scan is swept; if
// the receiver still stalls at the end of a sweep, the block waits with its
// input stalled until the output register is free. A stalled result holds.
// Reset puts every button at rest and the threshold at 1000 ms; the threshold
// is written over the APB-style port at byte address 0 and reads back there.
// The user writes it only while the block is idle; the block does not enforce it.
module multi_button_long_press_tracker #(
    parameter int unsigned BUTTONS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [mblp_pkg::MASK_W-1:0]          i_pressed_mask,
    input  logic [mblp_pkg::TIME_W-1:0]          i_now_ms,
    input  logic [mblp_pkg::QUERY_W-1:0]         i_query_button,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_any_active,
    output logic [3:0]                           o_first_button,
    output logic [2:0]                           o_query_state,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [mblp_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import mblp_pkg::*;

    logic [31:0] r_long_press_ms;
    logic        reg_hit;
    t_dp_cmd     cmd;
    t_dp_status  status;

    // Registers sit on 32-bit word boundaries; the low address bits are ignored.
    assign reg_hit = (paddr[CFG_ADDR_W-1:2] == REG_LONG_PRESS);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? r_long_press_ms : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_press_ms <= LONG_PRESS_RESET;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_long_press_ms <= pwdata;
        end
    end

    mblp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    mblp_datapath #(
        .BUTTONS (BUTTONS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_long_press_ms (r_long_press_ms),
        .i_pressed_mask  (i_pressed_mask),
        .i_now_ms        (i_now_ms),
        .i_query_button  (i_query_button),
        .o_any_active    (o_any_active),
        .o_first_button  (o_first_button),
        .o_query_state   (o_query_state)
    );

endmodule

// ===== tb/sv/tb_multi_button_long_press_tracker.sv =====
`timescale 1ns / 100ps

module tb_multi_button_long_press_tracker;

    import mblp_pkg::*;

    localparam int unsigned BUTTONS = 16;
    // The threshold register sits at word 0, so its byte address is the word index times four.
    localparam logic [CFG_ADDR_W-1:0] ADDR_LONG_PRESS = {REG_LONG_PRESS, 2'b00};

    // One scan word as it is handed to the block.
    typedef struct packed {
        logic [MASK_W-1:0]  mask;
        logic [TIME_W-1:0]  now;
        logic [QUERY_W-1:0] query;
    } t_scan;

    // One result word as the block should return it.
    typedef struct packed {
        logic       any_active;
        logic [3:0] first_button;
        t_class     query_state;
    } t_report;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [MASK_W-1:0]     i_pressed_mask = '0;
    logic [TIME_W-1:0]     i_now_ms = '0;
    logic [QUERY_W-1:0]    i_query_button = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic                  o_any_active;
    logic [3:0]            o_first_button;
    logic [2:0]            o_query_state;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    // Scan words waiting to be offered, and result words the block still owes us.
    t_scan   pending_scans[$];
    t_report expected_reports[$];

    // Our own copy of the per-button tracking state and of the threshold register.
    t_class      shadow_class [BUTTONS] = '{default: CLS_REST};
    logic [31:0] shadow_t0    [BUTTONS] = '{default: 32'd0};
    logic [31:0] shadow_limit = LONG_PRESS_RESET;

    // While calm is set neither side idles, which gives one long stretch at full rate.
    logic        calm = 1'b0;
    int unsigned mismatches = 0;

    // Stimulus state: how many more scans each button stays held, and the running clock.
    int unsigned hold_left [BUTTONS] = '{default: 0};
    logic [31:0] clock_ms = 32'd0;

    multi_button_long_press_tracker #(
        .BUTTONS(BUTTONS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_pressed_mask (i_pressed_mask),
        .i_now_ms       (i_now_ms),
        .i_query_button (i_query_button),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_any_active   (o_any_active),
        .o_first_button (o_first_button),
        .o_query_state  (o_query_state),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Apply one scan to the shadow state and return the result word that it produces.
    // The held time is the wrapping 32-bit difference, and it must strictly exceed the
    // threshold before a still-pressed button turns long.
    function automatic t_report track_scan(input logic [MASK_W-1:0] mask,
                                           input logic [TIME_W-1:0] now,
                                           input logic [QUERY_W-1:0] query);
        t_report r;
        r = '0;
        for (int b = 0; b < BUTTONS; b++) begin
            if (mask[b]) begin
                case (shadow_class[b])
                    CLS_PRESSED: begin
                        shadow_class[b] = CLS_STILL;
                    end
                    CLS_STILL: begin
                        if (now - shadow_t0[b] > shadow_limit) shadow_class[b] = CLS_LONG;
                    end
                    CLS_LONG, CLS_STILL_LONG: begin
                        shadow_class[b] = CLS_STILL_LONG;
                    end
                    default: begin
                        shadow_class[b] = CLS_PRESSED;
                        shadow_t0[b] = now;
                    end
                endcase
            end else begin
                case (shadow_class[b])
                    CLS_PRESSED, CLS_STILL, CLS_LONG, CLS_STILL_LONG: begin
                        shadow_class[b] = CLS_RELEASED;
                    end
                    default: begin
                        shadow_class[b] = CLS_REST;
                        shadow_t0[b] = 32'd0;
                    end
                endcase
            end
        end
        for (int b = 0; b < BUTTONS; b++) begin
            if (shadow_class[b] != CLS_REST && !r.any_active) begin
                r.any_active = 1'b1;
                r.first_button = 4'(b);
            end
        end
        r.query_state = shadow_class[query];
        return r;
    endfunction

    // Either side takes a break with a probability of 28 percent on each call unless calm is set.
    function automatic logic take_break();
        return !calm && ($urandom_range(0, 99) < 28);
    endfunction

    // The sender. A word is predicted at the edge where the block accepts it, and a new
    // word is only put on the bus when the previous one has gone or none was offered.
    always @(posedge i_clk) begin : scan_sender
        t_scan word;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_reports.push_back(
                    track_scan(i_pressed_mask, i_now_ms, i_query_button));
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_scans.size() != 0 && !take_break()) begin
                    word = pending_scans.pop_front();
                    i_in_valid     <= 1'b1;
                    i_pressed_mask <= word.mask;
                    i_now_ms       <= word.now;
                    i_query_button <= word.query;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // The receiver. Every accepted result word is checked against the oldest prediction.
    always @(posedge i_clk) begin : report_checker
        t_report want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_reports.size() == 0) begin
                    $error("result word with no scan outstanding");
                    mismatches++;
                end else begin
                    want = expected_reports.pop_front();
                    if (o_any_active !== want.any_active) begin
                        $error("any_active: expected %0d, got %0d",
                               want.any_active, o_any_active);
                        mismatches++;
                    end
                    if (o_first_button !== want.first_button) begin
                        $error("first_button: expected %0d, got %0d",
                               want.first_button, o_first_button);
                        mismatches++;
                    end
                    if (o_query_state !== want.query_state) begin
                        $error("query_state: expected %0d, got %0d",
                               want.query_state, o_query_state);
                        mismatches++;
                    end
                end
            end
            i_out_stall <= take_break();
        end
    end

    // Sampled on the falling edge so that the queues and the valid have settled.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_scans.size() != 0 || i_in_valid || expected_reports.size() != 0);
    endtask

    // One register access over the configuration port. A read compares the returned
    // value with the shadow copy; a write updates the shadow copy once it has landed.
    task automatic reg_access(input logic is_write, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= ADDR_LONG_PRESS;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (is_write) begin
            shadow_limit = value;
        end else if (prdata !== shadow_limit) begin
            $error("long_press_ms: expected %0d, got %0d", shadow_limit, prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic queue_scan(input logic [MASK_W-1:0] mask, input logic [TIME_W-1:0] now,
                              input logic [QUERY_W-1:0] query);
        pending_scans.push_back('{mask: mask, now: now, query: query});
    endtask

    // Random scans that behave like hands on the buttons: each button is held for a run
    // of scans and then let go, while the clock advances in steps scaled to the current
    // threshold so that presses regularly turn long. A few scans carry a random mask or
    // a jump of the clock to anywhere in its range.
    task automatic queue_random_scans(input int count);
        logic [MASK_W-1:0] mask;
        int unsigned       stride;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 4) begin
                clock_ms = $urandom();
            end else begin
                if (shadow_limit == 0)
                    stride = $urandom_range(0, 2);
                else if (shadow_limit > 2000)
                    stride = $urandom_range(0, 400);
                else
                    stride = $urandom_range(0, shadow_limit / 3 + 1);
                clock_ms += stride;
            end
            if ($urandom_range(0, 99) < 8) begin
                mask = MASK_W'($urandom_range(0, 16'hFFFF));
            end else begin
                for (int b = 0; b < BUTTONS; b++) begin
                    if (hold_left[b] != 0) begin
                        mask[b] = 1'b1;
                        hold_left[b]--;
                    end else if ($urandom_range(0, 99) < 6) begin
                        mask[b] = 1'b1;
                        hold_left[b] = $urandom_range(0, 30);
                    end else begin
                        mask[b] = 1'b0;
                    end
                end
            end
            queue_scan(mask, clock_ms, QUERY_W'($urandom_range(0, 15)));
        end
    endtask

    // Main sequence: reset, a directed part at the reset threshold, then random phases
    // each with its own threshold. Every phase is drained before the register moves, so
    // the sender also pauses several times until every result word has come back.
    initial begin : sequencer
        logic [31:0] limits [7];
        limits = '{32'd0, 32'd7, 32'd60, 32'hFFFF_FFFF, $urandom(), 32'd1000, 32'd1};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        reg_access(1'b0, 32'd0);

        // Directed part. All buttons pressed, held exactly to the threshold and one past it.
        queue_scan(16'h0000, 32'd0, 4'd0);
        queue_scan(16'hFFFF, 32'd100, 4'd15);
        queue_scan(16'hFFFF, 32'd200, 4'd3);
        queue_scan(16'hFFFF, 32'd1100, 4'd0);
        queue_scan(16'hFFFF, 32'd1101, 4'd7);
        queue_scan(16'hFFFF, 32'd1102, 4'd9);
        // Only the top button stays held; the rest are released, then go to rest.
        queue_scan(16'h8000, 32'd1103, 4'd15);
        queue_scan(16'h0000, 32'd1104, 4'd15);
        queue_scan(16'h0000, 32'd1105, 4'd15);
        queue_scan(16'h0000, 32'd1106, 4'd0);
        // A press that straddles the wrap of the millisecond clock.
        queue_scan(16'h0004, 32'hFFFF_FF00, 4'd2);
        queue_scan(16'h0004, 32'hFFFF_FF10, 4'd2);
        queue_scan(16'h0004, 32'h0000_02E8, 4'd2);
        queue_scan(16'h0004, 32'h0000_02E9, 4'd2);
        queue_scan(16'h0004, 32'h0000_02EA, 4'd2);
        // Released and pressed again straight from released.
        queue_scan(16'h0000, 32'h0000_0300, 4'd2);
        queue_scan(16'h0004, 32'h0000_0301, 4'd2);
        queue_scan(16'h0000, 32'h0000_0302, 4'd2);
        queue_scan(16'h0000, 32'h0000_0303, 4'd2);
        // A single-scan press is released from the pressed class.
        queue_scan(16'h0010, 32'h0000_0400, 4'd4);
        queue_scan(16'h0000, 32'h0000_0401, 4'd4);
        queue_scan(16'h5AA5, 32'h8000_0000, 4'd10);
        queue_scan(16'hA55A, 32'h7FFF_FFFF, 4'd5);
        queue_scan(16'h0000, 32'hFFFF_FFFF, 4'd1);
        queue_scan(16'h0000, 32'hFFFF_FFFF, 4'd11);

        clock_ms = $urandom();
        for (int p = 0; p < 7; p++) begin
            wait_drained();
            // The block is back in idle once the last word has come out; this wait adds margin.
            repeat (BUTTONS + 2) @(posedge i_clk);
            @(negedge i_clk);
            reg_access(1'b1, limits[p]);
            reg_access(1'b0, 32'd0);
            calm = (p == 2);
            queue_random_scans(186);
        end

        wait_drained();
        calm = 1'b0;
        repeat (BUTTONS + 4) @(posedge i_clk);
        if (mismatches == 0 && expected_reports.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin : watchdog
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
